FILE: rtl/escaped_frame_receiver_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the escaped frame receiver.
// Each macro expands to one labeled concurrent assertion that reports by $error.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_RECEIVER_DEFINES_SVH
`define ESCAPED_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EFR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/efr_pkg.sv
// ----------------------------------------------------------------------------
// efr_pkg
// Shared byte codes, result status codes and inter-module types.
// ----------------------------------------------------------------------------
package efr_pkg;

    localparam logic [7:0] HEAD_BYTE     = 8'h78;
    localparam logic [7:0] TAIL_BYTE     = 8'h79;
    localparam logic [7:0] ESC_BYTE      = 8'h77;
    localparam logic [7:0] ESC_CODE_ESC  = 8'h01;
    localparam logic [7:0] ESC_CODE_HEAD = 8'h02;
    localparam logic [7:0] ESC_CODE_TAIL = 8'h03;

    // Width of the per-frame decoded byte count.
    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        ST_GOOD  = 2'd0,
        ST_CSUM  = 2'd1,
        ST_OVER  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // One finished frame handed from the front to the back.
    typedef struct packed {
        logic               bank;
        logic [COUNT_W-1:0] count;
        status_t            status;
    } frame_desc_t;

    // The back gives a buffer bank back to the front when it has drained it.
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_release_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_EMIT = 1'b1
    } back_state_t;

endpackage

FILE: rtl/efr_ram.sv
// ----------------------------------------------------------------------------
// efr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module efr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/efr_queue.sv
// ----------------------------------------------------------------------------
// efr_queue
// Two-entry queue of finished frame descriptors between front and back.
// ----------------------------------------------------------------------------
module efr_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  efr_pkg::frame_desc_t push_desc,
    input  logic                 pop,
    output efr_pkg::frame_desc_t head_desc,
    output logic                 not_empty,
    output logic                 full
);

    efr_pkg::frame_desc_t entry_reg [2];
    logic                 wr_ptr_reg;
    logic                 wr_ptr_next;
    logic                 rd_ptr_reg;
    logic                 rd_ptr_next;
    logic [1:0]           fill_reg;
    logic [1:0]           fill_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    assign head_desc = entry_reg[rd_ptr_reg];
    assign not_empty = (fill_reg != 2'd0);
    assign full      = fill_reg[1];

endmodule

FILE: rtl/efr_front.sv
// ----------------------------------------------------------------------------
// efr_front
// Hunts for the head byte, removes escapes, writes decoded bytes to the frame
// buffer and classifies each frame at its tail byte.
// ----------------------------------------------------------------------------
module efr_front #(
    parameter int MAX_FRAME = 64,
    localparam int IDX_W = $clog2(MAX_FRAME)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             rx_byte,
    output logic                   ram_we,
    output logic [IDX_W:0]         ram_waddr,
    output logic [7:0]             ram_wdata,
    output logic                   q_push,
    output efr_pkg::frame_desc_t   q_desc,
    input  logic                   q_full,
    input  efr_pkg::bank_release_t rel_info
);

    localparam int CW = efr_pkg::COUNT_W;

    logic          in_frame_reg;
    logic          in_frame_next;
    logic          esc_reg;
    logic          esc_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [7:0]    xor_reg;
    logic [7:0]    xor_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic          bank_reg;
    logic          bank_next;
    logic [1:0]    busy_reg;
    logic [1:0]    busy_next;

    logic          blocked;
    logic          pair_code;
    logic          flush;
    logic          accept;
    logic          store_req;
    logic [7:0]    store_val;
    efr_pkg::status_t tail_status;

    always_comb
    begin
        blocked   = in_frame_reg && (busy_reg[bank_reg] || q_full);
        pair_code = (rx_byte == efr_pkg::ESC_CODE_ESC) || (rx_byte == efr_pkg::ESC_CODE_HEAD)
                    || (rx_byte == efr_pkg::ESC_CODE_TAIL);
        // A pending escape followed by a byte that is not an escape code first stalls
        // that byte while the literal escape byte is stored, then takes the byte itself.
        flush     = in_frame_reg && esc_reg && in_valid && !pair_code && !blocked;
        in_stall  = blocked || flush;
        accept    = in_valid && !in_stall;

        if (ovf_reg)
        begin
            tail_status = efr_pkg::ST_OVER;
        end
        else if (count_reg < CW'(2))
        begin
            tail_status = efr_pkg::ST_EMPTY;
        end
        else if (xor_reg != 8'h00)
        begin
            tail_status = efr_pkg::ST_CSUM;
        end
        else
        begin
            tail_status = efr_pkg::ST_GOOD;
        end
    end

    always_comb
    begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        count_next    = count_reg;
        xor_next      = xor_reg;
        ovf_next      = ovf_reg;
        bank_next     = bank_reg;
        busy_next     = busy_reg;
        store_req     = 1'b0;
        store_val     = rx_byte;
        q_push        = 1'b0;
        q_desc.bank   = bank_reg;
        q_desc.count  = count_reg;
        q_desc.status = tail_status;
        ram_we        = 1'b0;
        ram_waddr     = {bank_reg, count_reg[IDX_W-1:0]};
        ram_wdata     = store_val;

        if (rel_info.valid)
        begin
            busy_next[rel_info.bank] = 1'b0;
        end

        if (flush)
        begin
            store_req = 1'b1;
            store_val = efr_pkg::ESC_BYTE;
            esc_next  = 1'b0;
        end
        else if (accept)
        begin
            if (!in_frame_reg)
            begin
                if (rx_byte == efr_pkg::HEAD_BYTE)
                begin
                    in_frame_next = 1'b1;
                    esc_next      = 1'b0;
                    count_next    = '0;
                    xor_next      = 8'h00;
                    ovf_next      = 1'b0;
                end
            end
            else if (esc_reg)
            begin
                esc_next  = 1'b0;
                store_req = 1'b1;
                case (rx_byte)
                    efr_pkg::ESC_CODE_ESC:  store_val = efr_pkg::ESC_BYTE;
                    efr_pkg::ESC_CODE_HEAD: store_val = efr_pkg::HEAD_BYTE;
                    efr_pkg::ESC_CODE_TAIL: store_val = efr_pkg::TAIL_BYTE;
                    default:                store_val = efr_pkg::ESC_BYTE;
                endcase
            end
            else if (rx_byte == efr_pkg::TAIL_BYTE)
            begin
                q_push        = 1'b1;
                in_frame_next = 1'b0;
                esc_next      = 1'b0;
                count_next    = '0;
                xor_next      = 8'h00;
                ovf_next      = 1'b0;
                // A good frame keeps its bank until the back has drained it.
                if (tail_status == efr_pkg::ST_GOOD)
                begin
                    busy_next[bank_reg] = 1'b1;
                    bank_next           = ~bank_reg;
                end
            end
            else if (rx_byte == efr_pkg::ESC_BYTE)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                store_req = 1'b1;
            end
        end

        if (store_req)
        begin
            if (count_reg >= CW'(MAX_FRAME))
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                ram_we     = 1'b1;
                ram_wdata  = store_val;
                xor_next   = xor_reg ^ store_val;
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            count_reg    <= '0;
            xor_reg      <= 8'h00;
            ovf_reg      <= 1'b0;
            bank_reg     <= 1'b0;
            busy_reg     <= 2'b00;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
            count_reg    <= count_next;
            xor_reg      <= xor_next;
            ovf_reg      <= ovf_next;
            bank_reg     <= bank_next;
            busy_reg     <= busy_next;
        end
    end

endmodule

FILE: rtl/efr_back.sv
// ----------------------------------------------------------------------------
// efr_back
// Takes frame descriptors from the queue and drives the result channel:
// either one status result or the stored payload bytes read from the buffer.
// ----------------------------------------------------------------------------
module efr_back #(
    parameter int MAX_FRAME = 64,
    localparam int IDX_W = $clog2(MAX_FRAME)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  efr_pkg::frame_desc_t   q_desc,
    output logic                   q_pop,
    output logic                   ram_re,
    output logic [IDX_W:0]         ram_raddr,
    input  logic [7:0]             ram_rdata,
    output efr_pkg::bank_release_t rel_info,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             frame_byte,
    output logic                   last,
    output logic [1:0]             status
);

    localparam int CW = efr_pkg::COUNT_W;

    efr_pkg::back_state_t state_reg;
    efr_pkg::back_state_t state_next;
    logic                 cur_bank_reg;
    logic                 cur_bank_next;
    logic [CW-1:0]        cur_count_reg;
    logic [CW-1:0]        cur_count_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           out_byte_reg;
    logic [7:0]           out_byte_next;
    logic                 out_last_reg;
    logic                 out_last_next;
    efr_pkg::status_t     out_status_reg;
    efr_pkg::status_t     out_status_next;

    logic                 out_free;
    logic                 at_last;
    logic                 load;

    assign out_free = !out_valid_reg || !out_stall;
    // The byte in the read register is the final payload byte of the frame.
    assign at_last  = (CW'(idx_reg) == (cur_count_reg - CW'(2)));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            efr_pkg::BK_IDLE:
            begin
                if (q_valid && (q_desc.status == efr_pkg::ST_GOOD))
                begin
                    state_next = efr_pkg::BK_EMIT;
                end
            end
            efr_pkg::BK_EMIT:
            begin
                if (out_free && at_last)
                begin
                    state_next = efr_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = efr_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop           = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = {cur_bank_reg, idx_reg};
        rel_info.valid  = 1'b0;
        rel_info.bank   = cur_bank_reg;
        cur_bank_next   = cur_bank_reg;
        cur_count_next  = cur_count_reg;
        idx_next        = idx_reg;
        load            = 1'b0;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;

        case (state_reg)
            efr_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_desc.status == efr_pkg::ST_GOOD)
                    begin
                        q_pop          = 1'b1;
                        ram_re         = 1'b1;
                        ram_raddr      = {q_desc.bank, {IDX_W{1'b0}}};
                        cur_bank_next  = q_desc.bank;
                        cur_count_next = q_desc.count;
                        idx_next       = '0;
                    end
                    else if (out_free)
                    begin
                        q_pop           = 1'b1;
                        load            = 1'b1;
                        out_byte_next   = 8'h00;
                        out_last_next   = 1'b1;
                        out_status_next = q_desc.status;
                    end
                end
            end
            efr_pkg::BK_EMIT:
            begin
                if (out_free)
                begin
                    load            = 1'b1;
                    out_byte_next   = ram_rdata;
                    out_last_next   = at_last;
                    out_status_next = efr_pkg::ST_GOOD;
                    if (at_last)
                    begin
                        rel_info.valid = 1'b1;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = {cur_bank_reg, idx_reg + IDX_W'(1)};
                        idx_next  = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                load = 1'b0;
            end
        endcase

        out_valid_next = load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= efr_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_bank_reg   <= cur_bank_next;
        cur_count_reg  <= cur_count_next;
        idx_reg        <= idx_next;
        out_byte_reg   <= out_byte_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = out_byte_reg;
    assign last       = out_last_reg;
    assign status     = out_status_reg;

endmodule

FILE: rtl/escaped_frame_receiver.sv
// Escaped frame receiver: raw link bytes go in on the rx channel (in_valid,
// in_stall, rx_byte); decoded frame results come out on the result channel
// (out_valid, out_stall, frame_byte, last, status). A transfer happens at a
// clock edge where valid is high and stall is low.
// The front takes one byte per cycle. It stalls a byte that follows an escape
// byte and is not an escape code while it stores the literal escape byte, and
// it stalls inside a frame while both frame buffer banks are held by undrained
// frames or the descriptor queue is full. Bytes outside a frame never stall.
// With the back idle, a status result (checksum error, overflow or empty
// frame) is offered from the back's output register after its descriptor has
// passed through the queue; a good frame first reads its first payload byte
// into the buffer's registered read port and then drains one byte per cycle
// while the result channel is not stalled, the final one marked with last.
// When the receiver stalls, the held result stays on the port unchanged and
// the front keeps taking bytes of the next frame, into the other bank when
// the held frame is good. Reset clears all control state; the buffer needs no
// clearing pass since only bytes written in the current frame are read.
// ----------------------------------------------------------------------------
// escaped_frame_receiver
// Top level: front deframer, descriptor queue, back drainer and frame buffer.
// ----------------------------------------------------------------------------
module escaped_frame_receiver #(
    parameter int MAX_FRAME = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] frame_byte,
    output logic       last,
    output logic [1:0] status
);

    // Two banks of a power-of-two size, addressed as {bank, index}.
    localparam int IDX_W     = $clog2(MAX_FRAME);
    localparam int RAM_DEPTH = 2 * (1 << IDX_W);

    logic                   ram_we;
    logic [IDX_W:0]         ram_waddr;
    logic [7:0]             ram_wdata;
    logic                   ram_re;
    logic [IDX_W:0]         ram_raddr;
    logic [7:0]             ram_rdata;

    logic                   q_push;
    efr_pkg::frame_desc_t   q_push_desc;
    logic                   q_full;
    logic                   q_pop;
    efr_pkg::frame_desc_t   q_head_desc;
    logic                   q_not_empty;

    efr_pkg::bank_release_t rel_info;

    // Front: hunting, escape removal, buffer writes and frame classification.
    efr_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .q_push    (q_push),
        .q_desc    (q_push_desc),
        .q_full    (q_full),
        .rel_info  (rel_info)
    );

    // Descriptors of finished frames wait here for the back.
    efr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (q_push_desc),
        .pop       (q_pop),
        .head_desc (q_head_desc),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    // Frame buffer: the front writes one bank while the back reads the other.
    efr_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Back: drives the result channel through its output register.
    efr_back #(
        .MAX_FRAME (MAX_FRAME)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_not_empty),
        .q_desc     (q_head_desc),
        .q_pop      (q_pop),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .rel_info   (rel_info),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .last       (last),
        .status     (status)
    );

endmodule

FILE: rtl/efr_checker.sv
// ----------------------------------------------------------------------------
// efr_checker
// Port-level checks of the escaped frame receiver's result channel.
// ----------------------------------------------------------------------------
`include "escaped_frame_receiver_defines.svh"

module efr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] frame_byte,
    input logic       last,
    input logic [1:0] status
);

    // A result held by the receiver keeps its payload.
    `EFR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(frame_byte) && $stable(last) && $stable(status), "result changed while stalled")

    // Status results are single, marked last and carry a zero byte.
    `EFR_ASSERT_SAME(a_status_form, clk, rst_n, out_valid && (status != 2'd0), last && (frame_byte == 8'h00), "malformed status result")

    // Only a good payload byte may leave without the last mark.
    `EFR_ASSERT_SAME(a_nonlast_good, clk, rst_n, out_valid && !last, status == 2'd0, "unmarked result is not a payload byte")

    // A good frame drains without gaps once it has started.
    `EFR_ASSERT_NEXT(a_drain_gapless, clk, rst_n, out_valid && !out_stall && !last, out_valid && (status == 2'd0), "gap inside a frame's payload")

endmodule

bind escaped_frame_receiver efr_checker u_efr_checker (.*);

FILE: tb/sv/escaped_frame_receiver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_frame_receiver_test
// Self-checking test of the escaped frame receiver. Link bytes are sent as
// directed frames for the corner cases, then as random well-formed, corrupt,
// short, oversized and broken frames. A tracker class decodes every accepted
// byte on its own and holds the results the block owes, in order. Each result
// transfer is compared field by field against the oldest one it holds.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_test;

    import efr_pkg::*;

    localparam int MAX_FRAME    = 64;
    localparam int RANDOM_ITEMS = 380;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int SETTLE_CYCLES = 20;

    // One result as the block should present it.
    typedef struct {
        logic [7:0] data;
        logic       last;
        status_t    status;
    } frame_result_t;

    // Decodes the link byte stream the same way the block must, and keeps the
    // queue of results that are still owed by the block.
    class deframe_tracker;
        logic          in_frame;
        logic          esc_seen;
        logic [6:0]    decoded_count;
        logic [7:0]    parity;
        logic          overflowed;
        logic [7:0]    frame_buf [MAX_FRAME];
        frame_result_t awaited_results [$];
        int            fail_count;

        function new();
            in_frame   = 1'b0;
            fail_count = 0;
            open_frame();
        endfunction

        function void open_frame();
            esc_seen      = 1'b0;
            decoded_count = '0;
            parity        = '0;
            overflowed    = 1'b0;
        endfunction

        function void keep_byte(logic [7:0] b);
            if (decoded_count >= MAX_FRAME)
            begin
                overflowed = 1'b1;
                return;
            end
            frame_buf[decoded_count] = b;
            parity = parity ^ b;
            decoded_count = decoded_count + 7'd1;
        endfunction

        function void push_status(status_t code);
            awaited_results.push_back('{8'h00, 1'b1, code});
        endfunction

        // Overflow wins over shortness, and shortness over a bad checksum.
        function void close_frame();
            int i;
            if (overflowed)
            begin
                push_status(ST_OVER);
            end
            else if (decoded_count < 2)
            begin
                push_status(ST_EMPTY);
            end
            else if (parity != 8'h00)
            begin
                push_status(ST_CSUM);
            end
            else
            begin
                for (i = 0; i < int'(decoded_count) - 1; i++)
                begin
                    awaited_results.push_back('{frame_buf[i],
                        (i == int'(decoded_count) - 2), ST_GOOD});
                end
            end
            in_frame = 1'b0;
            open_frame();
        endfunction

        function void note_rx_byte(logic [7:0] b);
            if (!in_frame)
            begin
                if (b == HEAD_BYTE)
                begin
                    in_frame = 1'b1;
                    open_frame();
                end
                return;
            end
            if (esc_seen)
            begin
                esc_seen = 1'b0;
                case (b)
                    ESC_CODE_ESC:
                    begin
                        keep_byte(ESC_BYTE);
                        return;
                    end
                    ESC_CODE_HEAD:
                    begin
                        keep_byte(HEAD_BYTE);
                        return;
                    end
                    ESC_CODE_TAIL:
                    begin
                        keep_byte(TAIL_BYTE);
                        return;
                    end
                    // Not a valid pair: the escape byte stands as a literal and
                    // the current byte is handled on its own below.
                    default: keep_byte(ESC_BYTE);
                endcase
            end
            if (b == TAIL_BYTE)
            begin
                close_frame();
            end
            else if (b == ESC_BYTE)
            begin
                esc_seen = 1'b1;
            end
            else
            begin
                keep_byte(b);
            end
        endfunction

        function void report(string what);
            fail_count++;
            if (fail_count <= 10)
            begin
                $display("%t ERROR: %s", $realtime, what);
            end
        endfunction

        function void check_result(logic [7:0] data, logic lst, logic [1:0] st);
            frame_result_t want;
            if (awaited_results.size() == 0)
            begin
                report($sformatf("unexpected result data=%h last=%b status=%0d",
                                 data, lst, st));
                return;
            end
            want = awaited_results.pop_front();
            if (data !== want.data || lst !== want.last || st !== want.status)
            begin
                report($sformatf({"result mismatch: expected data=%h last=%b status=%0d,",
                                  " got data=%h last=%b status=%0d"},
                                 want.data, want.last, want.status, data, lst, st));
            end
        endfunction

        function void flag_missing();
            frame_result_t want;
            while (awaited_results.size() > 0)
            begin
                want = awaited_results.pop_front();
                report($sformatf("missing result data=%h last=%b status=%0d",
                                 want.data, want.last, want.status));
            end
        endfunction
    endclass

    // Clock, reset and the block's ports. Every input starts at a known value.
    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] frame_byte;
    logic       last;
    logic [1:0] status;

    // Test control shared between the sender and the receiver processes.
    bit             quiet        = 1'b0;
    bit             hold_request = 1'b0;
    int             sent_items   = 0;
    logic [7:0]     link_q [$];
    deframe_tracker tracker      = new();

    escaped_frame_receiver #(
        .MAX_FRAME (MAX_FRAME)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .last       (last),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs a handshake.
    initial
    begin
        #2_000_000;
        $display("FAIL escaped_frame_receiver");
        $finish;
    end

    // All inputs change only at rising edges, so at the falling edge the
    // handshake signals are settled. A valid without stall seen here means the
    // transfer happens at the next rising edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                tracker.note_rx_byte(rx_byte);
            end
            if (out_valid && !out_stall)
            begin
                tracker.check_result(frame_byte, last, status);
            end
        end
    end

    // Result side. It stalls at random, not at all during a quiet stretch, and
    // holds off for a long counted stretch when the sender asks for it, so that
    // both buffer banks fill and the block has to stall its input.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (quiet)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < 13);
            end
        end
    end

    // Offers one byte and waits for the rising edge that takes it. Called just
    // after a rising edge. Sometimes the sender then idles with valid low before
    // returning, which keeps it idle about 13 percent of the time.
    task automatic send_byte(input logic [7:0] b);
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(negedge clk);
        while (in_stall) @(negedge clk);
        @(posedge clk);
        if (!quiet && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Sends every queued link byte and counts each one.
    task automatic send_link();
        while (link_q.size() > 0)
        begin
            send_byte(link_q.pop_front());
            sent_items++;
        end
    endtask

    // Data values lean toward the framing and escape codes, since that is
    // where the decoder has its decisions to make.
    function automatic logic [7:0] pick_data();
        logic [7:0] specials [8];
        specials = '{ESC_BYTE, HEAD_BYTE, TAIL_BYTE, ESC_CODE_ESC, ESC_CODE_HEAD,
                     ESC_CODE_TAIL, 8'h00, 8'hFF};
        if ($urandom_range(3) == 0)
        begin
            return specials[$urandom_range(7)];
        end
        return 8'($urandom);
    endfunction

    // Puts one decoded byte on the link. A head byte inside a frame may go
    // either escaped or as a plain literal.
    function automatic void encode_data(logic [7:0] v);
        if (v == ESC_BYTE)
        begin
            link_q.push_back(ESC_BYTE);
            link_q.push_back(ESC_CODE_ESC);
        end
        else if (v == TAIL_BYTE)
        begin
            link_q.push_back(ESC_BYTE);
            link_q.push_back(ESC_CODE_TAIL);
        end
        else if (v == HEAD_BYTE && $urandom_range(1) == 1)
        begin
            link_q.push_back(ESC_BYTE);
            link_q.push_back(ESC_CODE_HEAD);
        end
        else
        begin
            link_q.push_back(v);
        end
    endfunction

    // Queues a frame of n_decoded decoded bytes, the last being the checksum.
    // With corrupt set the checksum is off by a nonzero pattern.
    function automatic void build_frame(int n_decoded, bit corrupt);
        logic [7:0] sum;
        logic [7:0] v;
        int         k;
        sum = 8'h00;
        link_q.push_back(HEAD_BYTE);
        for (k = 0; k < n_decoded - 1; k++)
        begin
            v   = pick_data();
            sum = sum ^ v;
            encode_data(v);
        end
        if (n_decoded > 0)
        begin
            encode_data(corrupt ? (sum ^ 8'($urandom_range(255, 1))) : sum);
        end
        link_q.push_back(TAIL_BYTE);
    endfunction

    // One random piece of link traffic. Most of it is well-formed frames with
    // random content; the rest is corrupt, short, oversized or raw garbage
    // inside a frame, sometimes with no tail so the next head lands inside it.
    task automatic send_random_frame();
        int         pick;
        int         n;
        int         k;
        logic [7:0] v;
        if ($urandom_range(4) == 0)
        begin
            repeat ($urandom_range(6, 1))
            begin
                v = pick_data();
                link_q.push_back((v == HEAD_BYTE) ? 8'h7A : v);
            end
            send_link();
        end
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            n = ($urandom_range(19) == 0) ? $urandom_range(MAX_FRAME, 40)
                                          : $urandom_range(15, 2);
            build_frame(n, 1'b0);
        end
        else if (pick < 67)
        begin
            build_frame($urandom_range(15, 2), 1'b1);
        end
        else if (pick < 73)
        begin
            build_frame($urandom_range(1, 0), $urandom_range(1));
        end
        else if (pick < 77)
        begin
            build_frame($urandom_range(MAX_FRAME + 6, MAX_FRAME + 1), $urandom_range(1));
        end
        else
        begin
            link_q.push_back(HEAD_BYTE);
            n = $urandom_range(20, 1);
            for (k = 0; k < n; k++)
            begin
                v = pick_data();
                link_q.push_back((v == TAIL_BYTE) ? ESC_BYTE : v);
            end
            if ($urandom_range(9) < 7)
            begin
                link_q.push_back(TAIL_BYTE);
            end
        end
        send_link();
    endtask

    initial
    begin
        int  i;
        bit  pressure_done;
        bit  quiet_done;
        pressure_done = 1'b0;
        quiet_done    = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames: ignored bytes outside a frame, the extreme data
        // values, an empty frame, a one-byte frame, a bad checksum, all three
        // escape pairs, a head byte inside a frame, an escape followed by an
        // ordinary byte, and an escape followed by the tail.
        link_q = '{8'h00, 8'hFF, TAIL_BYTE, ESC_BYTE, ESC_CODE_ESC,
                   HEAD_BYTE, 8'h00, 8'h00, TAIL_BYTE,
                   HEAD_BYTE, 8'hFF, 8'hFF, TAIL_BYTE,
                   HEAD_BYTE, TAIL_BYTE,
                   HEAD_BYTE, 8'h5A, TAIL_BYTE,
                   HEAD_BYTE, 8'h12, 8'h34, 8'h00, TAIL_BYTE,
                   HEAD_BYTE, ESC_BYTE, ESC_CODE_ESC, ESC_BYTE, ESC_CODE_HEAD,
                   ESC_BYTE, ESC_CODE_TAIL, 8'h76, TAIL_BYTE,
                   HEAD_BYTE, HEAD_BYTE, 8'hAA, 8'hD2, TAIL_BYTE,
                   HEAD_BYTE, ESC_BYTE, 8'h55, 8'h22, TAIL_BYTE,
                   HEAD_BYTE, ESC_BYTE, ESC_BYTE, TAIL_BYTE};
        send_link();

        // Largest good frame, then the smallest overflow. The overflow frame
        // carries a valid checksum, so overflow must take priority.
        build_frame(MAX_FRAME, 1'b0);
        build_frame(MAX_FRAME + 1, 1'b0);
        send_link();

        while (sent_items < RANDOM_ITEMS)
        begin
            if (!pressure_done && sent_items >= RANDOM_ITEMS / 3)
            begin
                // The receiver holds off while mid-sized good frames keep
                // coming, so both buffer banks fill and the input stalls.
                pressure_done = 1'b1;
                hold_request  = 1'b1;
                repeat (3) build_frame($urandom_range(40, 20), 1'b0);
                send_link();
            end
            else if (!quiet_done && sent_items >= (2 * RANDOM_ITEMS) / 3)
            begin
                // Back-to-back traffic with no pauses on either side.
                quiet_done = 1'b1;
                quiet      = 1'b1;
                repeat (6) send_random_frame();
                quiet      = 1'b0;
            end
            else
            begin
                send_random_frame();
            end
        end
        in_valid <= 1'b0;

        // Wait for every owed result, then a few more cycles to catch extras.
        for (i = 0; i < DRAIN_LIMIT && tracker.awaited_results.size() > 0; i++)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        tracker.flag_missing();

        if (tracker.fail_count == 0)
        begin
            $display("PASS escaped_frame_receiver");
        end
        else
        begin
            $display("FAIL escaped_frame_receiver");
        end
        $finish;
    end

endmodule
